[rtl/brl_pkg.sv]
// ----------------------------------------------------------------------------
// brl_pkg - Bresenham line rasterizer shared definitions
// Coordinate widths, derived arithmetic widths, request codes and word types.
// ----------------------------------------------------------------------------
package brl_pkg;

    localparam int COORD_BITS  = 12;
    localparam int STEP_BITS   = COORD_BITS + 1;   // pixels left on the line
    localparam int ERR_BITS    = COORD_BITS + 3;   // signed decision variable
    localparam int SINC_BITS   = COORD_BITS + 1;   // straight increment, >= 0
    localparam int DINC_BITS   = COORD_BITS + 2;   // diagonal increment, <= 0
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef logic [COORD_BITS-1:0] t_coord;

    // request codes
    localparam logic REQ_START   = 1'b0;
    localparam logic REQ_ADVANCE = 1'b1;

    typedef struct packed {
        logic   req_type;
        t_coord x_start;
        t_coord y_start;
        t_coord x_stop;
        t_coord y_stop;
    } t_req;

    typedef struct packed {
        t_coord pixel_x;
        t_coord pixel_y;
        logic   pixel_valid;
        logic   last_pixel;
    } t_pix;

    // classified command, front to back
    typedef struct packed {
        logic   is_start;
        logic   x_neg;
        logic   y_neg;
        t_coord dx;
        t_coord dy;
        t_coord x0;
        t_coord y0;
    } t_cmd;

endpackage

[rtl/brl_front.sv]
// ----------------------------------------------------------------------------
// brl_front - request classifier
// Decodes the request, takes step signs and absolute deltas of a start word.
// ----------------------------------------------------------------------------
module brl_front
    import brl_pkg::*;
(
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_req i_in_data,
    output logic o_push,
    input  logic i_q_ready,
    output t_cmd o_cmd
);

    logic x_neg;
    logic y_neg;

    assign x_neg = i_in_data.x_stop < i_in_data.x_start;
    assign y_neg = i_in_data.y_stop < i_in_data.y_start;

    assign o_in_ready = i_q_ready;
    assign o_push     = i_in_valid & i_q_ready;

    always_comb begin
        o_cmd          = '0;
        o_cmd.is_start = (i_in_data.req_type == REQ_START);
        if (o_cmd.is_start) begin
            o_cmd.x_neg = x_neg;
            o_cmd.y_neg = y_neg;
            o_cmd.dx    = x_neg ? i_in_data.x_start - i_in_data.x_stop
                                : i_in_data.x_stop - i_in_data.x_start;
            o_cmd.dy    = y_neg ? i_in_data.y_start - i_in_data.y_stop
                                : i_in_data.y_stop - i_in_data.y_start;
            o_cmd.x0    = i_in_data.x_start;
            o_cmd.y0    = i_in_data.y_start;
        end
    end

endmodule

[rtl/brl_queue.sv]
// ----------------------------------------------------------------------------
// brl_queue - command queue
// Small register FIFO between classifier and stepper.
// ----------------------------------------------------------------------------
module brl_queue
    import brl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_ready,
    output logic o_valid,
    input  logic i_pop,
    output t_cmd o_cmd
);

    t_cmd                 r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QCNT_BITS-1:0] r_count;
    logic [QPTR_BITS-1:0] n_wr_ptr;
    logic [QPTR_BITS-1:0] n_rd_ptr;
    logic [QCNT_BITS-1:0] n_count;

    assign o_ready = (r_count != QCNT_BITS'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != QCNT_BITS'(QUEUE_DEPTH)) || i_pop)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue pop while empty");
`endif

endmodule

[rtl/brl_back.sv]
// ----------------------------------------------------------------------------
// brl_back - line stepper
// Holds the line state, steps one pixel per command, registers the result.
// ----------------------------------------------------------------------------
module brl_back
    import brl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_valid,
    input  t_cmd i_cmd,
    output logic o_pop,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_pix o_out_data
);

    t_coord                       r_cur_x;
    t_coord                       r_cur_y;
    logic [STEP_BITS-1:0]         r_steps;
    logic signed [ERR_BITS-1:0]   r_err;
    logic [SINC_BITS-1:0]         r_inc_s;
    logic signed [DINC_BITS-1:0]  r_inc_d;
    logic                         r_x_neg;
    logic                         r_y_neg;
    logic                         r_x_major;
    logic                         r_active;
    logic                         r_out_valid;
    t_pix                         r_out;

    t_coord                       n_cur_x;
    t_coord                       n_cur_y;
    logic [STEP_BITS-1:0]         n_steps;
    logic signed [ERR_BITS-1:0]   n_err;
    logic [SINC_BITS-1:0]         n_inc_s;
    logic signed [DINC_BITS-1:0]  n_inc_d;
    logic                         n_x_neg;
    logic                         n_y_neg;
    logic                         n_x_major;
    logic                         n_active;
    t_pix                         n_out;

    logic                         x_major;
    t_coord                       major;
    t_coord                       minor;
    logic                         diag;
    t_coord                       step_x;
    t_coord                       step_y;

    // take a command when the output register is free or being drained
    assign o_pop       = i_q_valid & (~r_out_valid | i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign x_major = (i_cmd.dx >= i_cmd.dy);
    assign major   = x_major ? i_cmd.dx : i_cmd.dy;
    assign minor   = x_major ? i_cmd.dy : i_cmd.dx;
    assign diag    = ~r_err[ERR_BITS-1];
    assign step_x  = r_x_neg ? r_cur_x - 1'b1 : r_cur_x + 1'b1;
    assign step_y  = r_y_neg ? r_cur_y - 1'b1 : r_cur_y + 1'b1;

    always_comb begin
        n_cur_x   = r_cur_x;
        n_cur_y   = r_cur_y;
        n_steps   = r_steps;
        n_err     = r_err;
        n_inc_s   = r_inc_s;
        n_inc_d   = r_inc_d;
        n_x_neg   = r_x_neg;
        n_y_neg   = r_y_neg;
        n_x_major = r_x_major;
        n_active  = r_active;
        n_out     = '0;
        if (i_cmd.is_start) begin
            n_x_neg   = i_cmd.x_neg;
            n_y_neg   = i_cmd.y_neg;
            n_x_major = x_major;
            n_err     = $signed({2'b00, minor, 1'b0}) - $signed({3'b000, major});
            n_inc_s   = {minor, 1'b0};
            n_inc_d   = $signed({1'b0, minor, 1'b0}) - $signed({1'b0, major, 1'b0});
            n_steps   = {1'b0, major};
            n_cur_x   = i_cmd.x0;
            n_cur_y   = i_cmd.y0;
            n_active  = (major != '0);
            n_out.pixel_x     = i_cmd.x0;
            n_out.pixel_y     = i_cmd.y0;
            n_out.pixel_valid = 1'b1;
            n_out.last_pixel  = (major == '0);
        end else if (r_active) begin
            if (r_x_major) begin
                n_cur_x = step_x;
                n_cur_y = diag ? step_y : r_cur_y;
            end else begin
                n_cur_y = step_y;
                n_cur_x = diag ? step_x : r_cur_x;
            end
            n_err    = diag ? r_err + {r_inc_d[DINC_BITS-1], r_inc_d}
                            : r_err + $signed({2'b00, r_inc_s});
            n_steps  = r_steps - 1'b1;
            n_active = (r_steps != STEP_BITS'(1));
            n_out.pixel_x     = n_cur_x;
            n_out.pixel_y     = n_cur_y;
            n_out.pixel_valid = 1'b1;
            n_out.last_pixel  = (r_steps == STEP_BITS'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_steps     <= '0;
            r_err       <= '0;
            r_inc_s     <= '0;
            r_inc_d     <= '0;
            r_x_neg     <= 1'b0;
            r_y_neg     <= 1'b0;
            r_x_major   <= 1'b1;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_cur_x   <= n_cur_x;
                r_cur_y   <= n_cur_y;
                r_steps   <= n_steps;
                r_err     <= n_err;
                r_inc_s   <= n_inc_s;
                r_inc_d   <= n_inc_d;
                r_x_neg   <= n_x_neg;
                r_y_neg   <= n_y_neg;
                r_x_major <= n_x_major;
                r_active  <= n_active;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    a_active_has_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_steps != '0))
        else $error("active line with no steps left");
    a_zero_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_cmd.is_start && i_cmd.dx == '0 && i_cmd.dy == '0) |=> !r_active)
        else $error("zero-length line left active");
    a_last_is_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.last_pixel) |-> r_out.pixel_valid)
        else $error("last flag on an empty result");
    a_idle_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && !i_cmd.is_start && !r_active) |=> (!r_active && !r_out.pixel_valid))
        else $error("advance without a line produced a pixel");
`endif

endmodule

[rtl/bresenham_line_rasterizer_core.sv]
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_core - all-octant Bresenham line rasterizer
// Start words load two endpoints and emit the first pixel; advance words emit the next pixel.
// ----------------------------------------------------------------------------
//
//  channel  | valid / ready                | word
//  ---------+------------------------------+---------------------------------
//  request  | i_in_valid  / o_in_ready     | i_in_data  (t_req)
//  pixel    | o_out_valid / i_out_ready    | o_out_data (t_pix)
//
//  One word in, one word out; one request per clock sustained while the pixel side stays ready.
//  An accepted request is written into the queue; the stepper then pops it
//  and writes its pixel word to the output register.
//  The stepper's error-term add/compare loop sets the one-per-clock rate.
//  Reset (i_rst_n low, synchronous) empties the queue and drops any line.
//  A stall on the pixel side fills the two-word queue, then drops o_in_ready.
//
module bresenham_line_rasterizer_core
    import brl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_pix o_out_data
);

    logic push;
    logic pop;
    logic q_ready;
    logic q_valid;
    t_cmd push_cmd;
    t_cmd head_cmd;

    // front: decode, signs and absolute deltas
    brl_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_push     (push),
        .i_q_ready  (q_ready),
        .o_cmd      (push_cmd)
    );

    // decoupling queue
    brl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_cmd   (head_cmd)
    );

    // back: line state, stepping and output register
    brl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

[dv/bresenham_line_rasterizer_core_tb.sv]
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_core_tb - self-checking bench for the rasterizer
// A queue of request words (directed lines first, then random short lines in
// every octant mixed with broken sequences) feeds a valid/ready driver. Each
// accepted word runs through an in-bench line stepper, and the monitor checks
// every pixel word against the oldest predicted one, field by field.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer_core_tb;
    import brl_pkg::*;

    localparam int TAIL_WORDS     = 60;    // no idling once this few remain
    localparam int RANDOM_TARGET  = 500;
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving
    localparam int SETTLE_CYCLES  = 8;

    typedef struct {
        t_req word;
        bit   drain;   // hold this word back until every pixel is home
    } t_queued_req;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic in_valid    = 1'b0;
    t_req in_data     = '0;
    logic out_ready   = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_pix o_out_data;

    t_queued_req pending_words[$];
    t_pix        pix_expected[$];
    int          mismatches = 0;
    int          send_gap   = 0;
    int          recv_stall = 0;
    int          quiet_cycles = 0;

    // In-bench copy of the line stepper state
    t_coord                       pen_x       = '0;
    t_coord                       pen_y       = '0;
    logic [STEP_BITS-1:0]         steps_to_go = '0;
    logic signed [ERR_BITS-1:0]   decision    = '0;
    logic [SINC_BITS-1:0]         inc_flat    = '0;
    logic signed [DINC_BITS-1:0]  inc_diag    = '0;
    logic                         x_back      = 1'b0;
    logic                         y_back      = 1'b0;
    logic                         x_major     = 1'b1;
    logic                         drawing     = 1'b0;

    bresenham_line_rasterizer_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Line stepper prediction
    // ------------------------------------------------------------------------
    function automatic t_coord nudge(t_coord c, logic back);
        return back ? c - 1'b1 : c + 1'b1;
    endfunction

    task automatic predict_pixel(input t_req w);
        t_pix p;
        int   xs, ys, xe, ye, dx, dy, major, minor, e;
        logic diag;
        p = '0;
        if (w.req_type == REQ_START) begin
            xs = int'(w.x_start);
            ys = int'(w.y_start);
            xe = int'(w.x_stop);
            ye = int'(w.y_stop);
            x_back  = xe < xs;
            y_back  = ye < ys;
            dx      = x_back ? xs - xe : xe - xs;
            dy      = y_back ? ys - ye : ye - ys;
            x_major = dx >= dy;             // ties go to x
            major   = x_major ? dx : dy;
            minor   = x_major ? dy : dx;
            decision    = ERR_BITS'(2 * minor - major);
            inc_flat    = SINC_BITS'(2 * minor);
            inc_diag    = DINC_BITS'(2 * (minor - major));
            steps_to_go = STEP_BITS'(major);
            pen_x   = w.x_start;
            pen_y   = w.y_start;
            drawing = major != 0;           // zero length: one pixel, done
            p.pixel_x     = pen_x;
            p.pixel_y     = pen_y;
            p.pixel_valid = 1'b1;
            p.last_pixel  = !drawing;
        end else if (drawing) begin
            diag = decision >= 0;           // zero error steps the minor axis
            if (x_major) begin
                pen_x = nudge(pen_x, x_back);
                if (diag) pen_y = nudge(pen_y, y_back);
            end else begin
                pen_y = nudge(pen_y, y_back);
                if (diag) pen_x = nudge(pen_x, x_back);
            end
            e = int'(decision) + (diag ? int'(inc_diag) : int'(inc_flat));
            decision    = ERR_BITS'(e);
            steps_to_go = steps_to_go - 1'b1;
            drawing     = steps_to_go != 0;
            p.pixel_x     = pen_x;
            p.pixel_y     = pen_y;
            p.pixel_valid = 1'b1;
            p.last_pixel  = !drawing;
        end
        // advance with no line leaves p all zero
        pix_expected.push_back(p);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------------
    task automatic queue_start(input int xs, input int ys, input int xe, input int ye,
                               input bit drain);
        t_queued_req q;
        q.word          = '0;
        q.word.req_type = REQ_START;
        q.word.x_start  = t_coord'(xs);
        q.word.y_start  = t_coord'(ys);
        q.word.x_stop   = t_coord'(xe);
        q.word.y_stop   = t_coord'(ye);
        q.drain         = drain;
        pending_words.push_back(q);
    endtask

    task automatic queue_advances(input int count);
        t_queued_req q;
        repeat (count) begin
            // endpoint fields are don't-care on an advance: fill with noise
            q.word.req_type = REQ_ADVANCE;
            q.word.x_start  = t_coord'($urandom);
            q.word.y_start  = t_coord'($urandom);
            q.word.x_stop   = t_coord'($urandom);
            q.word.y_stop   = t_coord'($urandom);
            q.drain         = 1'b0;
            pending_words.push_back(q);
        end
    endtask

    // endpoint a short random distance away, kept on the canvas
    function automatic int near_coord(int c, int reach);
        int d, r;
        d = $urandom_range(0, reach);
        r = $urandom_range(0, 1) ? c + d : c - d;
        if (r > 4095) r = c - d;
        if (r < 0) r = c + d;
        return r;
    endfunction

    task automatic queue_random_line();
        int xs, ys, xe, ye, steps, reach, n, pick;
        xs    = $urandom_range(0, 4095);
        ys    = $urandom_range(0, 4095);
        reach = ($urandom_range(0, 7) == 0) ? 40 : 12;
        xe    = near_coord(xs, reach);
        ye    = near_coord(ys, reach);
        steps = (xe > xs ? xe - xs : xs - xe);
        n     = (ye > ys ? ye - ys : ys - ye);
        if (n > steps) steps = n;
        pick = $urandom_range(0, 9);
        if (pick < 2) n = $urandom_range(0, steps);                // cut short by next start
        else if (pick < 4) n = steps + $urandom_range(1, 2);       // runs past the end
        else n = steps;
        queue_start(xs, ys, xe, ye, $urandom_range(0, 19) == 0);
        queue_advances(n);
    endtask

    // ------------------------------------------------------------------------
    // Driver: presents queued request words
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                predict_pixel(in_data);
            end
            if (!in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (pending_words.size() != 0 &&
                             !(pending_words[0].drain && pix_expected.size() != 0)) begin
                    in_data  <= pending_words[0].word;
                    in_valid <= 1'b1;
                    pending_words.pop_front();
                    if (pending_words.size() > TAIL_WORDS && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 5);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: takes pixel words and checks them in order
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pix want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (pix_expected.size() == 0) begin
                    mismatches++;
                    $display("%0t: pixel word with none expected, actual %h", $time,
                             o_out_data);
                end else begin
                    want = pix_expected.pop_front();
                    if (o_out_data.pixel_x !== want.pixel_x) begin
                        mismatches++;
                        $display("%0t: pixel_x expected %0d actual %0d", $time,
                                 want.pixel_x, o_out_data.pixel_x);
                    end
                    if (o_out_data.pixel_y !== want.pixel_y) begin
                        mismatches++;
                        $display("%0t: pixel_y expected %0d actual %0d", $time,
                                 want.pixel_y, o_out_data.pixel_y);
                    end
                    if (o_out_data.pixel_valid !== want.pixel_valid) begin
                        mismatches++;
                        $display("%0t: pixel_valid expected %b actual %b", $time,
                                 want.pixel_valid, o_out_data.pixel_valid);
                    end
                    if (o_out_data.last_pixel !== want.last_pixel) begin
                        mismatches++;
                        $display("%0t: last_pixel expected %b actual %b", $time,
                                 want.last_pixel, o_out_data.last_pixel);
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                out_ready <= 1'b0;
            end else if (pending_words.size() > TAIL_WORDS && $urandom_range(0, 6) == 0) begin
                recv_stall = $urandom_range(0, 4);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: nothing moving on either channel for too long
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        // advance straight out of reset: no line yet
        queue_advances(1);
        // zero-length line, then an advance with nothing left
        queue_start(100, 100, 100, 100, 1'b0);
        queue_advances(1);
        // corner to corner, dropped part way by a reverse line
        queue_start(0, 0, 4095, 4095, 1'b0);
        queue_advances(2);
        queue_start(4095, 4095, 0, 0, 1'b1);
        queue_advances(2);
        // error term starts at zero: minor axis steps on the first advance
        queue_start(10, 10, 12, 11, 1'b0);
        queue_advances(2);
        // steep, x and y falling
        queue_start(50, 50, 48, 45, 1'b0);
        queue_advances(5);
        // shallow, x and y falling
        queue_start(20, 30, 14, 27, 1'b0);
        queue_advances(6);

        begin
            int target;
            target = pending_words.size() + RANDOM_TARGET;
            while (pending_words.size() < target) begin
                case ($urandom_range(0, 9))
                    0: queue_advances(1);      // stray advance
                    1: begin                   // unrelated far endpoints, few steps
                        queue_start($urandom_range(0, 4095), $urandom_range(0, 4095),
                                    $urandom_range(0, 4095), $urandom_range(0, 4095), 1'b0);
                        queue_advances($urandom_range(0, 3));
                    end
                    default: queue_random_line();
                endcase
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() != 0 || in_valid || pix_expected.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pix_expected.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
